FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on the rising edge and
// disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/sqs_pkg.sv
// ----------------------------------------------------------------------------
// sqs_pkg
// types and constants shared by the indexed sequence store
// ----------------------------------------------------------------------------
`default_nettype none

package sqs_pkg;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_REMOVE     = 3'd5
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // what the cell row does this cycle
  typedef enum logic [1:0] {
    EDIT_NONE,
    EDIT_INSERT,
    EDIT_REMOVE
  } edit_e;

  typedef struct packed {
    status_e status;
    edit_e   edit;
  } dec_t;

endpackage

`default_nettype wire

FILE: rtl/core/sqs_cell.sv
// ----------------------------------------------------------------------------
// sqs_cell
// one storage cell of the sequence row; loads a new value, takes its
// front or back neighbor, or holds
// ----------------------------------------------------------------------------
`default_nettype none

module sqs_cell
  import sqs_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  edit_e                      edit_i,
  input  wire logic [IDX_W-1:0]      tgt_i,
  input  wire logic [DATA_WIDTH-1:0] din_i,
  input  wire logic [DATA_WIDTH-1:0] prev_i,
  input  wire logic [DATA_WIDTH-1:0] next_i,
  output logic      [DATA_WIDTH-1:0] data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (edit_i)
      EDIT_INSERT: begin
        // open a gap at the target, later cells move back
        if (MyIdx == tgt_i) begin
          data_d = din_i;
        end else if (MyIdx > tgt_i) begin
          data_d = prev_i;
        end
      end
      EDIT_REMOVE: begin
        // close the gap, later cells move front
        if (MyIdx >= tgt_i) begin
          data_d = next_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/sqs_decode.sv
// ----------------------------------------------------------------------------
// sqs_decode
// checks an operation against the fill level and picks the edit, the
// target cell and the next count
// ----------------------------------------------------------------------------
`default_nettype none

module sqs_decode
  import sqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic [OPCODE_W-1:0]          opcode_i,
  input  wire logic [POS_W-1:0]             position_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]   count_i,
  output dec_t                              dec_o,
  output logic      [$clog2(DEPTH)-1:0]     tgt_o,
  output logic      [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CMP_W-1:0] pos_w, cnt_w;
  logic             full, empty;
  opcode_e          op;

  assign pos_w = CMP_W'(position_i);
  assign cnt_w = CMP_W'(count_i);
  assign full  = (count_i == CNT_W'(DEPTH));
  assign empty = (count_i == '0);
  assign op    = opcode_e'(opcode_i);

  always_comb begin
    dec_o.status = ST_OK;
    dec_o.edit   = EDIT_NONE;
    tgt_o        = '0;
    unique case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (full) begin
          dec_o.status = ST_FULL;
        end else if (op == OP_PUSH_BACK) begin
          dec_o.edit = EDIT_INSERT;
          tgt_o      = IDX_W'(count_i);
        end else if (op == OP_PUSH_FRONT) begin
          dec_o.edit = EDIT_INSERT;
        end else if (pos_w > cnt_w) begin
          dec_o.status = ST_RANGE;
        end else begin
          dec_o.edit = EDIT_INSERT;
          tgt_o      = IDX_W'(pos_w);
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_REMOVE: begin
        if (empty) begin
          dec_o.status = ST_EMPTY;
        end else if (op == OP_POP_BACK) begin
          dec_o.edit = EDIT_REMOVE;
          tgt_o      = IDX_W'(count_i - CNT_W'(1));
        end else if (op == OP_POP_FRONT) begin
          dec_o.edit = EDIT_REMOVE;
        end else if (pos_w >= cnt_w) begin
          dec_o.status = ST_RANGE;
        end else begin
          dec_o.edit = EDIT_REMOVE;
          tgt_o      = IDX_W'(pos_w);
        end
      end
      default: begin
        dec_o.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    unique case (dec_o.edit)
      EDIT_INSERT: count_o = count_i + CNT_W'(1);
      EDIT_REMOVE: count_o = count_i - CNT_W'(1);
      default:     count_o = count_i;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store
// bounded ordered sequence (deque with indexed insert and remove) held in
// a row of shifting cells, cell 0 at the front
// ----------------------------------------------------------------------------
//  channel   handshake        ports
//  command   start / busy     opcode_i, value_i, position_i
//  result    done_o strobe    taken_value_o, element_count_o, status_o
//
//  one word per cycle: the whole cell row shifts in parallel, so a command
//  accepted at one edge has its result on the ports for the following cycle
//  busy stays low; a new command may be given in every cycle
//  the receiver cannot stall; each result shows for exactly one cycle
//  reset clears the element count and the result strobe; cell contents are
//  undefined until written and are never read before that
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module indexed_sequence_store
  import sqs_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // command word
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic        [OPCODE_W-1:0] opcode_i,
  input  wire logic signed [VALUE_W-1:0]  value_i,
  input  wire logic        [POS_W-1:0]    position_i,
  // result word
  output logic                            done_o,
  output logic signed      [VALUE_W-1:0]  taken_value_o,
  output logic             [COUNT_W-1:0]  element_count_o,
  output logic             [STATUS_W-1:0] status_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // control state
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  logic             accept;

  // decode of the current command
  dec_t             dec;
  logic [IDX_W-1:0] tgt;
  edit_e            edit;

  // cell row
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] din;

  // result payload
  logic [VALUE_W-1:0]  taken_q, taken_d;
  logic [COUNT_W-1:0]  ecount_q;
  logic [STATUS_W-1:0] status_q;

  // every command completes in its own cycle, so the block never holds off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // value kept in its low DATA_WIDTH bits, zero-filled above 32
  assign din = DATA_WIDTH'($unsigned(value_i));

  sqs_decode #(
    .DEPTH(DEPTH)
  ) u_decode (
    .opcode_i  (opcode_i),
    .position_i(position_i),
    .count_i   (count_q),
    .dec_o     (dec),
    .tgt_o     (tgt),
    .count_o   (count_d)
  );

  // the row only moves on an accepted word
  assign edit = accept ? dec.edit : EDIT_NONE;

  // chain of cells; the front cell sees the new value as its front
  // neighbor, the back cell sees itself as its back neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w, next_w;

    if (i == 0) begin : g_front
      assign prev_w = din;
    end else begin : g_mid_prev
      assign prev_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign next_w = cell_data[i];
    end else begin : g_mid_next
      assign next_w = cell_data[i+1];
    end

    sqs_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX_W     (IDX_W),
      .INDEX     (i)
    ) u_cell (
      .clk_i (clk_i),
      .edit_i(edit),
      .tgt_i (tgt),
      .din_i (din),
      .prev_i(prev_w),
      .next_i(next_w),
      .data_o(cell_data[i])
    );
  end

  // taken word is the target cell before the row shifts
  assign taken_d = (dec.edit == EDIT_REMOVE) ? VALUE_W'(cell_data[tgt]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      taken_q  <= taken_d;
      ecount_q <= COUNT_W'(count_d);
      status_q <= dec.status;
    end
  end

  assign done_o          = done_q;
  assign taken_value_o   = taken_q;
  assign element_count_o = ecount_q;
  assign status_o        = status_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // fill level never passes the row length
  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH))

  // an accepted word is answered in the next cycle
  `ASSERT_NEXT(a_done_follows, clk_i, rst_ni, accept, done_o)

  // refused words leave the fill level alone and take nothing
  `ASSERT_SAME(a_refused_hold, clk_i, rst_ni, done_o && (status_o != ST_OK),
               (count_q == $past(count_q)) && (taken_value_o == '0))

  // the fill level moves by at most one per word
  `ASSERT_NEXT(a_count_step, clk_i, rst_ni, accept,
               (count_q == $past(count_q)) ||
               (count_q == $past(count_q) + CNT_W'(1)) ||
               (count_q == $past(count_q) - CNT_W'(1)))

endmodule

`default_nettype wire
